// ----- src/sfr_pkg.sv -----
package sfr_pkg;

  localparam int BYTE_W      = 8;
  localparam int WIN_DEPTH   = 8;
  localparam int CNT_W       = 4;
  localparam int CFG_W       = 64;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [WIN_DEPTH-1:0][BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]                 len;
    logic                             last;
    logic                             found;
    logic                             marker;
  } burst_load_t;

  function automatic logic [BYTE_W-1:0] byte_at(input logic [CFG_W-1:0] word,
                                                input logic [2:0] idx);
    byte_at = word[idx*BYTE_W +: BYTE_W];
  endfunction

endpackage

// ----- src/sfr_cell.sv -----
module sfr_cell (
  input  logic                      clk,
  input  logic                      shift,
  input  logic                      sel_new,
  input  logic [sfr_pkg::BYTE_W-1:0] din,
  input  logic [sfr_pkg::BYTE_W-1:0] pat_byte,
  output logic [sfr_pkg::BYTE_W-1:0] q,
  output logic [sfr_pkg::BYTE_W-1:0] post,
  output logic                      hit
);
  import sfr_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= din;
    end
  end

  assign post = sel_new ? din : q;
  assign hit  = (post == pat_byte);

endmodule

// ----- src/sfr_burst.sv -----
module sfr_burst (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  sfr_pkg::burst_load_t      load_data,
  input  logic                      out_stall,
  output logic                      can_load,
  output logic                      out_valid,
  output logic [sfr_pkg::BYTE_W-1:0] out_byte,
  output logic                      byte_valid,
  output logic                      last_result,
  output logic                      pattern_found
);
  import sfr_pkg::*;

  logic [WIN_DEPTH-1:0][BYTE_W-1:0] slots;
  logic [CNT_W-1:0]                 count;
  logic                             last_flag;
  logic                             found_flag;
  logic                             marker_flag;
  logic                             take;

  assign out_valid = (count != '0);
  assign take      = out_valid && !out_stall;
  assign can_load  = (count == '0) || ((count == CNT_W'(1)) && !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= load_data.len;
    end else if (take) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots       <= load_data.bytes;
      last_flag   <= load_data.last;
      found_flag  <= load_data.found;
      marker_flag <= load_data.marker;
    end else if (take) begin
      for (int j = 0; j < WIN_DEPTH - 1; j++) begin
        slots[j] <= slots[j+1];
      end
    end
  end

  assign out_byte      = slots[0];
  assign byte_valid    = !marker_flag;
  assign last_result   = last_flag && (count == CNT_W'(1));
  assign pattern_found = found_flag && (count == CNT_W'(1));

endmodule

// ----- src/stream_find_and_replace.sv -----
// Channel  Handshake           Payload
// in       in_valid, in_stall  text_byte, has_byte, end_of_text
// out      out_valid, out_stall out_byte, byte_valid, last_result, pattern_found
// cfg      cfg_write           cfg_index, cfg_data
//
// Each accepted item gives zero to eight results; while out_stall is low they leave one per cycle
// from a burst register; the next item is taken in the cycle the last result of a burst leaves.
// A stream of items that each give at most one result thus runs at one item per cycle when unstalled.
// The byte window is a row of cells, newest byte in the first cell, each comparing its byte
// against the pattern in the cycle the item is accepted.
// Synchronous reset clears the window fill, match flag, burst count and registers, but sets pattern length to one.
// A stall on the output holds the burst and, through it, stalls the input.
module stream_find_and_replace #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sfr_pkg::CFG_W-1:0]       cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     text_byte,
  input  logic                           has_byte,
  input  logic                           end_of_text,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           byte_valid,
  output logic                           last_result,
  output logic                           pattern_found
);
  import sfr_pkg::*;

  localparam int PAT_CAP = (MAX_PATTERN < WIN_DEPTH) ? MAX_PATTERN : WIN_DEPTH;
  localparam int REP_CAP = (MAX_REPLACEMENT < WIN_DEPTH) ? MAX_REPLACEMENT : WIN_DEPTH;

  logic [CFG_W-1:0] pattern_bytes;
  logic [CNT_W-1:0] pattern_length;
  logic [CFG_W-1:0] replacement_bytes;
  logic [CNT_W-1:0] replacement_length;
  logic [CNT_W-1:0] window_count;
  logic [CNT_W-1:0] window_count_next;
  logic             match_seen;
  logic             match_seen_next;

  logic [CNT_W-1:0] plen;
  logic [CNT_W-1:0] rlen;
  logic [CNT_W-1:0] keep;
  logic [CNT_W-1:0] fill;
  logic             in_accept;
  logic             can_load;
  logic             full;
  logic             match;
  logic             all_hit;
  logic [CNT_W-1:0] emit_len;
  burst_load_t      burst;

  logic [PAT_CAP-1:0][BYTE_W-1:0] cell_q;
  logic [PAT_CAP-1:0][BYTE_W-1:0] cell_post;
  logic [PAT_CAP-1:0][BYTE_W-1:0] cell_pat;
  logic [PAT_CAP-1:0]             cell_hit;

  assign in_stall  = !can_load;
  assign in_accept = in_valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= CNT_W'(1);
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_PATTERN_BYTES:      pattern_bytes      <= cfg_data;
        REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[CNT_W-1:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
        REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pattern_length == '0) begin
      plen = CNT_W'(1);
    end else if (pattern_length > CNT_W'(PAT_CAP)) begin
      plen = CNT_W'(PAT_CAP);
    end else begin
      plen = pattern_length;
    end
    if (replacement_length > CNT_W'(REP_CAP)) begin
      rlen = CNT_W'(REP_CAP);
    end else begin
      rlen = replacement_length;
    end
  end

  genvar k;
  generate
    for (k = 0; k < PAT_CAP; k++) begin : g_cell
      logic [CNT_W-1:0] pidx;
      assign pidx        = plen - CNT_W'(k) - CNT_W'(1);
      assign cell_pat[k] = byte_at(pattern_bytes, pidx[2:0]);
      if (k == 0) begin : g_head
        sfr_cell u_cell (
          .clk      (clk),
          .shift    (in_accept && has_byte),
          .sel_new  (has_byte),
          .din      (text_byte),
          .pat_byte (cell_pat[k]),
          .q        (cell_q[k]),
          .post     (cell_post[k]),
          .hit      (cell_hit[k])
        );
      end else begin : g_body
        sfr_cell u_cell (
          .clk      (clk),
          .shift    (in_accept && has_byte),
          .sel_new  (has_byte),
          .din      (cell_q[k-1]),
          .pat_byte (cell_pat[k]),
          .q        (cell_q[k]),
          .post     (cell_post[k]),
          .hit      (cell_hit[k])
        );
      end
    end
  endgenerate

  always_comb begin
    keep    = (window_count > plen - CNT_W'(1)) ? plen - CNT_W'(1) : window_count;
    fill    = has_byte ? keep + CNT_W'(1) : window_count;
    full    = has_byte && (fill == plen);
    all_hit = 1'b1;
    for (int i = 0; i < PAT_CAP; i++) begin
      if ((CNT_W'(i) < plen) && !cell_hit[i]) begin
        all_hit = 1'b0;
      end
    end
    match = full && all_hit;

    if (full && !end_of_text) begin
      emit_len = CNT_W'(1);
    end else if (end_of_text) begin
      emit_len = fill;
    end else begin
      emit_len = '0;
    end

    burst.bytes  = '0;
    burst.len    = emit_len;
    burst.last   = end_of_text;
    burst.found  = end_of_text && (match_seen || match);
    burst.marker = 1'b0;
    if (match) begin
      for (int j = 0; j < WIN_DEPTH; j++) begin
        burst.bytes[j] = byte_at(replacement_bytes, 3'(j));
      end
      burst.len = rlen;
    end else begin
      for (int j = 0; j < WIN_DEPTH; j++) begin
        for (int i = 0; i < PAT_CAP; i++) begin
          if (CNT_W'(i + j + 1) == fill) begin
            burst.bytes[j] = cell_post[i];
          end
        end
      end
    end
    if (end_of_text && (burst.len == '0)) begin
      burst.len    = CNT_W'(1);
      burst.marker = 1'b1;
      burst.bytes  = '0;
    end

    if (end_of_text) begin
      window_count_next = '0;
    end else if (match) begin
      window_count_next = '0;
    end else if (full) begin
      window_count_next = plen - CNT_W'(1);
    end else begin
      window_count_next = fill;
    end
    match_seen_next = !end_of_text && (match_seen || match);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
      match_seen   <= 1'b0;
    end else if (in_accept) begin
      window_count <= window_count_next;
      match_seen   <= match_seen_next;
    end
  end

  sfr_burst u_burst (
    .clk           (clk),
    .rst           (rst),
    .load          (in_accept),
    .load_data     (burst),
    .out_stall     (out_stall),
    .can_load      (can_load),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .last_result   (last_result),
    .pattern_found (pattern_found)
  );

`ifndef SYNTHESIS
  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    window_count < CNT_W'(PAT_CAP))
    else $error("window fill beyond pattern capacity");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    in_accept && end_of_text |=> (window_count == '0) && !match_seen)
    else $error("window not cleared after end of text");

  a_found_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && pattern_found |-> last_result)
    else $error("pattern_found on a result that is not the last");

  a_no_load_when_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while a stalled burst is pending");
`endif

endmodule

// ----- tb/tb_stream_find_and_replace.sv -----
`timescale 1ns / 100ps

module tb_stream_find_and_replace;

  import sfr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       eot;
  } text_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic       valid;
    logic       last;
    logic       found;
  } text_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_PATTERN_BYTES;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             text_byte = 8'h00;
  logic                   has_byte = 1'b0;
  logic                   end_of_text = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [7:0]             out_byte;
  logic                   byte_valid;
  logic                   last_result;
  logic                   pattern_found;

  text_item_t   pending_items[$];
  text_result_t expected_results[$];
  int           items_in_flight = 0;
  int           items_sent = 0;
  int           mismatches = 0;
  int           cycle_count = 0;
  bit           steady = 1'b0;

  // Predictor state and its copy of the registers.
  logic [63:0] pattern_word = '0;
  logic [3:0]  pattern_len_reg = 4'd1;
  logic [63:0] subst_word = '0;
  logic [3:0]  subst_len_reg = 4'd0;
  logic [7:0]  window_bytes[8];
  int          window_fill = 0;
  logic        match_flag = 1'b0;

  logic [7:0]  char_a, char_b;

  stream_find_and_replace u_top (.*);

  always #5 clk = ~clk;

  function automatic int eff_pattern_len();
    if (pattern_len_reg == 0) return 1;
    if (pattern_len_reg > 8) return 8;
    return int'(pattern_len_reg);
  endfunction

  function automatic int eff_subst_len();
    if (subst_len_reg > 8) return 8;
    return int'(subst_len_reg);
  endfunction

  function automatic void drop_window(input int n);
    int i;
    if (n >= window_fill) begin
      window_fill = 0;
    end else begin
      for (i = 0; i + n < window_fill; i++) window_bytes[i] = window_bytes[i + n];
      window_fill -= n;
    end
  endfunction

  function automatic void replace_step(input logic [7:0] b, input logic has,
                                       input logic eot);
    int plen, rlen, i;
    logic hit;
    text_result_t burst[$];
    plen = eff_pattern_len();
    rlen = eff_subst_len();
    if (has) begin
      if (window_fill > plen - 1) drop_window(window_fill - (plen - 1));
      window_bytes[window_fill] = b;
      window_fill++;
      if (window_fill == plen) begin
        hit = 1'b1;
        for (i = 0; i < plen; i++) begin
          if (window_bytes[i] != pattern_word[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          for (i = 0; i < rlen; i++) burst.push_back('{subst_word[8*i +: 8], 1'b1, 1'b0, 1'b0});
          window_fill = 0;
          match_flag = 1'b1;
        end else begin
          burst.push_back('{window_bytes[0], 1'b1, 1'b0, 1'b0});
          drop_window(1);
        end
      end
    end
    if (eot) begin
      for (i = 0; i < window_fill; i++) burst.push_back('{window_bytes[i], 1'b1, 1'b0, 1'b0});
      if (burst.size() == 0) burst.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
      burst[burst.size() - 1].last = 1'b1;
      burst[burst.size() - 1].found = match_flag;
      window_fill = 0;
      match_flag = 1'b0;
    end
    foreach (burst[k]) expected_results.push_back(burst[k]);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : drive
    text_item_t next_item;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        replace_step(text_byte, has_byte, end_of_text);
        items_in_flight--;
      end
      if (pending_items.size() > 0 && (steady || $urandom_range(0, 99) >= 30)) begin
        next_item = pending_items.pop_front();
        in_valid <= 1'b1;
        text_byte <= next_item.data;
        has_byte <= next_item.has;
        end_of_text <= next_item.eot;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch
    text_result_t want;
    out_stall <= !steady && ($urandom_range(0, 99) < 30);
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got byte %0h valid %0b last %0b found %0b",
                 $time, out_byte, byte_valid, last_result, pattern_found);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("out_byte", want.value, out_byte);
        check_field("byte_valid", 8'(want.valid), 8'(byte_valid));
        check_field("last_result", 8'(want.last), 8'(last_result));
        check_field("pattern_found", 8'(want.found), 8'(pattern_found));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_item(input logic [7:0] b, input logic has, input logic eot);
    pending_items.push_back('{b, has, eot});
    items_in_flight++;
    if (has || eot) items_sent++;
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk);
    end while (items_in_flight != 0 || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [63:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_PATTERN_BYTES:      pattern_word = value;
      REG_PATTERN_LENGTH:     pattern_len_reg = value[3:0];
      REG_REPLACEMENT_BYTES:  subst_word = value;
      REG_REPLACEMENT_LENGTH: subst_len_reg = value[3:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [63:0] pat, input logic [3:0] plen,
                            input logic [63:0] rep, input logic [3:0] rlen);
    write_reg(REG_PATTERN_BYTES, pat);
    write_reg(REG_PATTERN_LENGTH, {60'd0, plen});
    write_reg(REG_REPLACEMENT_BYTES, rep);
    write_reg(REG_REPLACEMENT_LENGTH, {60'd0, rlen});
  endtask

  task automatic random_setup();
    logic [63:0] pat, rep;
    logic [3:0] plen, rlen;
    int k;
    char_a = 8'($urandom_range(0, 255));
    char_b = char_a ^ (8'h01 << $urandom_range(0, 7));
    for (k = 0; k < 8; k++) pat[8*k +: 8] = $urandom_range(0, 1) ? char_a : char_b;
    if ($urandom_range(0, 4) == 0) begin
      pat[31:0] = $urandom;
      pat[63:32] = $urandom;
    end
    rep[31:0] = $urandom;
    rep[63:32] = $urandom;
    k = $urandom_range(0, 19);
    if (k == 0) plen = 4'd0;
    else if (k <= 3) plen = 4'($urandom_range(9, 15));
    else plen = 4'($urandom_range(1, 8));
    if ($urandom_range(0, 9) == 0) rlen = 4'($urandom_range(9, 15));
    else rlen = 4'($urandom_range(0, 8));
    set_config(pat, plen, rep, rlen);
  endtask

  // Text made mostly of two close characters and whole copies of the pattern,
  // with some arbitrary bytes and ignored items mixed in.
  task automatic random_text(input bit close_text);
    int n, i, j, k;
    n = $urandom_range(0, 12);
    for (i = 0; i < n; i++) begin
      j = $urandom_range(0, 99);
      if (j < 30) begin
        for (k = 0; k < eff_pattern_len(); k++) push_item(pattern_word[8*k +: 8], 1'b1, 1'b0);
      end else if (j < 35) begin
        push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end else if (j < 50) begin
        push_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end else begin
        push_item($urandom_range(0, 1) ? char_a : char_b, 1'b1, 1'b0);
      end
    end
    if (close_text) begin
      if ($urandom_range(0, 1)) push_item($urandom_range(0, 1) ? char_a : char_b, 1'b1, 1'b1);
      else push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Single zero byte deleted, then end markers with and without a prior match.
    set_config(64'h0, 4'd1, 64'h0, 4'd0);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hFF, 1'b1, 1'b0);
    push_item(8'h5A, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'hA5, 1'b0, 1'b1);
    wait_idle();

    // Three byte pattern, full replacement, partial match flushed at the end.
    set_config(64'h434241, 4'd3, 64'h0011_2233_4455_66FF, 4'd8);
    push_item(8'h78, 1'b1, 1'b0);
    push_item(8'h41, 1'b1, 1'b0);
    push_item(8'h42, 1'b1, 1'b0);
    push_item(8'h43, 1'b1, 1'b0);
    push_item(8'h41, 1'b1, 1'b0);
    push_item(8'h42, 1'b1, 1'b1);
    wait_idle();

    // Both lengths above range act as eight.
    set_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 64'h0123_4567_89AB_CDEF, 4'd15);
    repeat (7) push_item(8'hFF, 1'b1, 1'b0);
    push_item(8'hFF, 1'b1, 1'b1);
    wait_idle();

    // Long pattern partly filled, then lowered to zero length mid-text.
    set_config(64'h1111_1111_1111_1111, 4'd8, 64'hAB, 4'd1);
    push_item(8'h11, 1'b1, 1'b0);
    push_item(8'h22, 1'b1, 1'b0);
    push_item(8'h33, 1'b1, 1'b0);
    wait_idle();
    write_reg(REG_PATTERN_LENGTH, 64'd0);
    write_reg(REG_PATTERN_BYTES, 64'h0);
    push_item(8'h00, 1'b1, 1'b1);
    wait_idle();

    while (items_sent < 240) begin
      steady = (items_sent >= 110 && items_sent < 200);
      random_setup();
      repeat ($urandom_range(1, 3)) random_text(1'b1);
      if ($urandom_range(0, 3) == 0) random_text(1'b0);
      wait_idle();
    end
    steady = 1'b0;
    push_item(8'h00, 1'b0, 1'b1);
    wait_idle();

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- stream_find_and_replace.f -----
src/sfr_pkg.sv
src/sfr_cell.sv
src/sfr_burst.sv
src/stream_find_and_replace.sv
tb/tb_stream_find_and_replace.sv
